[design/mpjs_pkg.sv]
// Package for the multi-policy job scheduler: payload structs, codes and sizes.
// Depends on nothing; every design file imports it.
package mpjs_pkg;

    localparam int JOB_SLOTS  = 16;
    localparam int SLOT_BITS  = $clog2(JOB_SLOTS);
    localparam int TIME_BITS  = 32;
    localparam int TOTAL_BITS = 48;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_NEW    = 2'd0,
        KIND_QUANTUM = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_IDLE     = 2'd2,
        ST_NONE_FIN = 2'd3
    } status_t;

    localparam logic [2:0] POL_FCFS = 3'd0;
    localparam logic [2:0] POL_PRI  = 3'd1;
    localparam logic [2:0] POL_PPRI = 3'd2;
    localparam logic [2:0] POL_SRTF = 3'd3;
    localparam logic [2:0] POL_RR   = 3'd4;
    localparam logic [2:0] POL_SJF  = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] event_time;
        logic [7:0]  job_tag;
        logic [31:0] run_length;
        logic [15:0] job_priority;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        next_valid;
        logic [7:0]  next_tag;
        logic [31:0] avg_wait;
        logic [31:0] avg_turnaround;
        logic [31:0] avg_response;
        logic [15:0] finished_total;
    } out_item_t;

    // One slot entry as stored in the job memory.
    typedef struct packed {
        logic [7:0]           tag;
        logic [TIME_BITS-1:0] arrival;
        logic                 start_set;
        logic [TIME_BITS-1:0] start;
        logic                 access_set;
        logic [TIME_BITS-1:0] access;
        logic [TIME_BITS-1:0] length;
        logic [TIME_BITS-1:0] remaining;
        logic [15:0]          priority_val;
    } slot_t;

    // Divider request and response between sequencer and divider.
    typedef struct packed {
        logic                  start;
        logic [TOTAL_BITS-1:0] dividend;
        logic [15:0]           divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [TOTAL_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

[design/mpjs_divider.sv]
// Restoring divider, one quotient bit per cycle, for the statistics averages.
// Depends on mpjs_pkg.
module mpjs_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  mpjs_pkg::div_req_t req,
    output mpjs_pkg::div_rsp_t rsp
);
    import mpjs_pkg::*;

    localparam int CNT_BITS = $clog2(TOTAL_BITS + 1);

    logic [TOTAL_BITS-1:0] quo_reg, quo_next;
    logic [16:0]           rem_reg, rem_next;
    logic [15:0]           dvs_reg, dvs_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [16:0]           trial;

    // One shift and subtract step per cycle.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quo_reg[TOTAL_BITS-1]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CNT_BITS'(TOTAL_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[TOTAL_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[TOTAL_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("divider did not start");
`endif

endmodule

[design/mpjs_slot_mem.sv]
// Job slot memory: one write port and one registered read port.
// Depends on mpjs_pkg.
module mpjs_slot_mem (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [mpjs_pkg::SLOT_BITS-1:0] wr_addr,
    input  mpjs_pkg::slot_t                wr_data,
    input  logic [mpjs_pkg::SLOT_BITS-1:0] rd_addr,
    output mpjs_pkg::slot_t                rd_data
);
    import mpjs_pkg::*;

    slot_t mem [JOB_SLOTS];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[design/multi_policy_job_scheduler_core.sv]
// Multi-policy job scheduler, top level: event sequencer over the slot memory.
// A new job, an idle finish and an empty query go straight to the result; a finish reads
// the running slot; a quantum expiry reads the running slot and then either keeps it or
// scans every slot; a query runs the 48-step divider three times in turn.
// One request is in work at a time; the next is taken once the result is taken.
// Reset (rst_n, asynchronous) empties the slot table, clears totals, policy fcfs.
module multi_policy_job_scheduler_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mpjs_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mpjs_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_data
);
    import mpjs_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_RDRUN  = 10'b0000000010,
        S_RUNDAT = 10'b0000000100,
        S_SCAN   = 10'b0000001000,
        S_RDBEST = 10'b0000010000,
        S_BESTD  = 10'b0000100000,
        S_DIV    = 10'b0001000000,
        S_DIVW   = 10'b0010000000,
        S_OUT    = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } state_t;

    localparam int SC_BITS = SLOT_BITS + 1;

    state_t                state_reg, state_next;
    logic [2:0]            policy_reg;
    logic [JOB_SLOTS-1:0]  valid_reg, valid_next;
    logic                  run_active_reg, run_active_next;
    logic [SLOT_BITS-1:0]  run_slot_reg, run_slot_next;
    logic [TIME_BITS-1:0]  lqt_reg, lqt_next;
    logic                  lqt_set_reg, lqt_set_next;
    logic [TOTAL_BITS-1:0] tw_reg, tw_next, tt_reg, tt_next, tr_reg, tr_next;
    logic [15:0]           fc_reg, fc_next;
    in_item_t              req_reg;
    out_item_t             res_reg, res_next;
    logic                  res_valid_reg, res_valid_next;
    logic [SC_BITS-1:0]    scan_reg, scan_next;
    logic                  scan_rd_reg, scan_rd_next;
    logic [SLOT_BITS-1:0]  scan_slot_reg, scan_slot_next;
    logic                  best_ok_reg, best_ok_next;
    logic [SLOT_BITS-1:0]  best_reg, best_next;
    logic [TIME_BITS:0]    bkey_reg, bkey_next;
    logic [TIME_BITS-1:0]  barr_reg, barr_next;
    logic [1:0]            dsel_reg, dsel_next;

    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_addr, rd_addr;
    slot_t                 wr_data, rd_data, upd;
    div_req_t              dreq;
    div_rsp_t              drsp;
    logic [TIME_BITS-1:0]  tnow, elapsed, turn, waitv, resp;
    logic [TIME_BITS:0]    key;
    logic                  free_ok;
    logic [SLOT_BITS-1:0]  free_slot;
    logic                  cand, better, accept;
    logic                  preempt;

    mpjs_slot_mem u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    mpjs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || res_valid_reg;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;
    assign cfg_ready = (state_reg == S_IDLE);
    assign tnow      = req_reg.event_time;
    assign preempt   = (policy_reg == POL_PPRI) || (policy_reg == POL_SRTF)
                    || (policy_reg == POL_RR);

    // Lowest free slot.
    always_comb
    begin
        free_ok   = 1'b0;
        free_slot = '0;
        for (int i = JOB_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_ok   = 1'b1;
                free_slot = SLOT_BITS'(i);
            end
        end
    end

    // Ordering key of the slot just read.
    always_comb
    begin
        case (policy_reg)
            POL_PRI, POL_PPRI: key = {{(TIME_BITS-15){1'b0}}, rd_data.priority_val};
            POL_SRTF:          key = {1'b0, rd_data.remaining};
            POL_RR:            key = rd_data.access_set ? {1'b0, rd_data.access} + 1'b1 : '0;
            POL_SJF:           key = {1'b0, rd_data.length};
            default:           key = {1'b0, rd_data.arrival};
        endcase
    end

    // Running job arithmetic.
    assign elapsed = (tnow >= lqt_reg) ? tnow - lqt_reg : '0;
    assign turn    = (tnow >= rd_data.arrival) ? tnow - rd_data.arrival : '0;
    assign waitv   = (turn > rd_data.length) ? turn - rd_data.length : '0;
    assign resp    = (rd_data.start >= rd_data.arrival) ? rd_data.start - rd_data.arrival : '0;

    function automatic logic [TOTAL_BITS-1:0] sat_add(logic [TOTAL_BITS-1:0] a,
                                                      logic [TIME_BITS-1:0] b);
        logic [TOTAL_BITS:0] s;
        s = {1'b0, a} + (TOTAL_BITS+1)'(b);
        return s[TOTAL_BITS] ? TOTAL_MAX : s[TOTAL_BITS-1:0];
    endfunction

    // Event sequencer.
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        run_active_next = run_active_reg;
        run_slot_next   = run_slot_reg;
        lqt_next        = lqt_reg;
        lqt_set_next    = lqt_set_reg;
        tw_next = tw_reg; tt_next = tt_reg; tr_next = tr_reg;
        fc_next         = fc_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        scan_next       = scan_reg;
        scan_rd_next    = 1'b0;
        scan_slot_next  = scan_slot_reg;
        best_ok_next    = best_ok_reg;
        best_next       = best_reg;
        bkey_next       = bkey_reg;
        barr_next       = barr_reg;
        dsel_next       = dsel_reg;
        wr_en           = 1'b0;
        wr_addr         = run_slot_reg;
        wr_data         = rd_data;
        rd_addr         = run_slot_reg;
        upd             = rd_data;
        dreq            = '0;
        cand            = 1'b0;
        better          = 1'b0;

        if (res_valid_reg && !out_stall)
        begin
            res_valid_next = 1'b0;
        end

        // Fold the slot read in the last cycle into the running best.
        if (scan_rd_reg)
        begin
            cand   = valid_reg[scan_slot_reg];
            better = !best_ok_reg || (key < bkey_reg)
                  || (key == bkey_reg && rd_data.arrival < barr_reg);
            if (cand && better)
            begin
                best_ok_next = 1'b1;
                best_next    = scan_slot_reg;
                bkey_next    = key;
                barr_next    = rd_data.arrival;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    res_next.finished_total = fc_reg;
                    case (kind_t'(in_data.kind))
                        KIND_NEW:
                        begin
                            if (!free_ok)
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = free_slot;
                                wr_data = '0;
                                wr_data.tag          = in_data.job_tag;
                                wr_data.arrival      = in_data.event_time;
                                wr_data.length       = in_data.run_length;
                                wr_data.remaining    = in_data.run_length;
                                wr_data.priority_val = in_data.job_priority;
                                valid_next[free_slot] = 1'b1;
                                state_next = S_OUT;
                            end
                        end
                        KIND_QUANTUM:
                        begin
                            if (!lqt_set_reg)
                            begin
                                lqt_next     = in_data.event_time;
                                lqt_set_next = 1'b1;
                            end
                            state_next = S_RDRUN;
                        end
                        KIND_FINISH:
                        begin
                            if (!run_active_reg)
                            begin
                                res_next.status = ST_IDLE;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                state_next = S_RDRUN;
                            end
                        end
                        default:
                        begin
                            if (fc_reg == '0)
                            begin
                                res_next.status = ST_NONE_FIN;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                dsel_next  = 2'd0;
                                state_next = S_DIV;
                            end
                        end
                    endcase
                end
            end
            S_RDRUN:
            begin
                rd_addr    = run_slot_reg;
                state_next = S_RUNDAT;
            end
            S_RUNDAT:
            begin
                if (req_reg.kind == KIND_FINISH)
                begin
                    tw_next = sat_add(tw_reg, waitv);
                    tt_next = sat_add(tt_reg, turn);
                    tr_next = sat_add(tr_reg, resp);
                    if (fc_reg != 16'hFFFF)
                    begin
                        fc_next = fc_reg + 1'b1;
                    end
                    res_next.finished_total = fc_next;
                    valid_next[run_slot_reg] = 1'b0;
                    run_active_next = 1'b0;
                    run_slot_next   = '0;
                    state_next      = S_OUT;
                end
                else
                begin
                    if (run_active_reg)
                    begin
                        upd.remaining  = (rd_data.remaining > elapsed)
                                       ? rd_data.remaining - elapsed : '0;
                        upd.access     = tnow;
                        upd.access_set = 1'b1;
                        wr_en   = 1'b1;
                        wr_addr = run_slot_reg;
                        wr_data = upd;
                    end
                    if (!run_active_reg || preempt)
                    begin
                        best_ok_next = 1'b0;
                        scan_next    = '0;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        best_ok_next = 1'b1;
                        best_next    = run_slot_reg;
                        state_next   = S_RDBEST;
                    end
                end
            end
            S_SCAN:
            begin
                // Step one slot per cycle over every slot; a running job takes part,
                // since a scan runs only when no job runs or the policy preempts.
                if (scan_reg != SC_BITS'(JOB_SLOTS))
                begin
                    rd_addr        = scan_reg[SLOT_BITS-1:0];
                    scan_slot_next = scan_reg[SLOT_BITS-1:0];
                    scan_rd_next   = 1'b1;
                    scan_next      = scan_reg + 1'b1;
                end
                else if (!scan_rd_reg)
                begin
                    state_next = S_RDBEST;
                end
            end
            S_RDBEST:
            begin
                if (!best_ok_reg)
                begin
                    res_next.status = ST_IDLE;
                    state_next      = S_OUT;
                end
                else
                begin
                    rd_addr    = best_reg;
                    state_next = S_BESTD;
                end
            end
            S_BESTD:
            begin
                upd = rd_data;
                if (!rd_data.start_set)
                begin
                    upd.start     = tnow;
                    upd.start_set = 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = best_reg;
                    wr_data = upd;
                end
                run_active_next     = 1'b1;
                run_slot_next       = best_reg;
                lqt_next            = tnow;
                res_next.next_valid = 1'b1;
                res_next.next_tag   = rd_data.tag;
                state_next          = S_OUT;
            end
            S_DIV:
            begin
                dreq.start   = 1'b1;
                dreq.divisor = fc_reg;
                case (dsel_reg)
                    2'd0:    dreq.dividend = tw_reg;
                    2'd1:    dreq.dividend = tt_reg;
                    default: dreq.dividend = tr_reg;
                endcase
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (drsp.done)
                begin
                    case (dsel_reg)
                        2'd0:    res_next.avg_wait       = drsp.quotient[31:0];
                        2'd1:    res_next.avg_turnaround = drsp.quotient[31:0];
                        default: res_next.avg_response   = drsp.quotient[31:0];
                    endcase
                    if (dsel_reg == 2'd2)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        dsel_next  = dsel_reg + 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_OUT:
            begin
                res_valid_next = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            policy_reg     <= POL_FCFS;
            valid_reg      <= '0;
            run_active_reg <= 1'b0;
            run_slot_reg   <= '0;
            lqt_reg        <= '0;
            lqt_set_reg    <= 1'b0;
            tw_reg         <= '0;
            tt_reg         <= '0;
            tr_reg         <= '0;
            fc_reg         <= '0;
            res_valid_reg  <= 1'b0;
            scan_rd_reg    <= 1'b0;
            best_ok_reg    <= 1'b0;
            dsel_reg       <= '0;
            scan_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
            valid_reg      <= valid_next;
            run_active_reg <= run_active_next;
            run_slot_reg   <= run_slot_next;
            lqt_reg        <= lqt_next;
            lqt_set_reg    <= lqt_set_next;
            tw_reg         <= tw_next;
            tt_reg         <= tt_next;
            tr_reg         <= tr_next;
            fc_reg         <= fc_next;
            res_valid_reg  <= res_valid_next;
            scan_rd_reg    <= scan_rd_next;
            best_ok_reg    <= best_ok_next;
            dsel_reg       <= dsel_next;
            scan_reg       <= scan_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
        res_reg       <= res_next;
        scan_slot_reg <= scan_slot_next;
        best_reg      <= best_next;
        bkey_reg      <= bkey_next;
        barr_reg      <= barr_next;
    end

`ifndef SYNTH
    a_run_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (run_active_reg && state_reg == S_IDLE) |-> valid_reg[run_slot_reg])
        else $error("running slot is not occupied");
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> in_stall)
        else $error("request taken while a result waits");
    a_fc_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (fc_reg != $past(fc_reg)) |-> (state_reg == S_OUT))
        else $error("finished count moved outside a finish");
`endif

endmodule

[sim/multi_policy_job_scheduler_core_tb.sv]
// Testbench for the multi-policy job scheduler core: directed and random events
// under every policy, checked against a behavioral scheduler model kept here.
// Depends on mpjs_pkg and multi_policy_job_scheduler_core.
`timescale 1ns / 100ps

module multi_policy_job_scheduler_core_tb;
    import mpjs_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_data;

    // Scheduler model state.
    logic [2:0]  mdl_policy;
    logic        mdl_valid [JOB_SLOTS];
    logic [7:0]  mdl_tag [JOB_SLOTS];
    logic [31:0] mdl_arrival [JOB_SLOTS];
    logic [31:0] mdl_start [JOB_SLOTS];
    logic        mdl_start_set [JOB_SLOTS];
    logic [31:0] mdl_access [JOB_SLOTS];
    logic        mdl_access_set [JOB_SLOTS];
    logic [31:0] mdl_length [JOB_SLOTS];
    logic [31:0] mdl_remaining [JOB_SLOTS];
    logic [15:0] mdl_priority [JOB_SLOTS];
    logic        mdl_running;
    int          mdl_run_slot;
    logic [31:0] mdl_last_quantum;
    logic        mdl_last_quantum_set;
    logic [47:0] mdl_total_wait;
    logic [47:0] mdl_total_turn;
    logic [47:0] mdl_total_resp;
    logic [15:0] mdl_finished;

    out_item_t expected_results [$];
    int  error_count;
    int  cycle_count;
    int  long_hold;
    logic [31:0] now_ticks;

    multi_policy_job_scheduler_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on total run length.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Ordering key of a slot under the current policy.
    function automatic logic [32:0] order_key(int i);
        case (mdl_policy)
            POL_PRI, POL_PPRI: order_key = {17'd0, mdl_priority[i]};
            POL_SRTF: order_key = {1'b0, mdl_remaining[i]};
            POL_RR: order_key = mdl_access_set[i] ? {1'b0, mdl_access[i]} + 33'd1 : 33'd0;
            POL_SJF: order_key = {1'b0, mdl_length[i]};
            default: order_key = {1'b0, mdl_arrival[i]};
        endcase
    endfunction

    function automatic int best_slot(bit with_running);
        int best;
        logic [32:0] ka;
        logic [32:0] kb;
        best = -1;
        for (int i = 0; i < JOB_SLOTS; i++)
        begin
            if (!mdl_valid[i]) continue;
            if (!with_running && mdl_running && i == mdl_run_slot) continue;
            if (best < 0)
            begin
                best = i;
                continue;
            end
            ka = order_key(i);
            kb = order_key(best);
            if (ka < kb || (ka == kb && mdl_arrival[i] < mdl_arrival[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic logic [47:0] add_capped(logic [47:0] total, logic [31:0] v);
        logic [48:0] s;
        s = {1'b0, total} + {17'd0, v};
        return s[48] ? TOTAL_MAX : s[47:0];
    endfunction

    function automatic void model_reset();
        mdl_policy = POL_FCFS;
        for (int i = 0; i < JOB_SLOTS; i++)
        begin
            mdl_valid[i] = 1'b0;
            mdl_start_set[i] = 1'b0;
            mdl_access_set[i] = 1'b0;
        end
        mdl_running = 1'b0;
        mdl_run_slot = 0;
        mdl_last_quantum = '0;
        mdl_last_quantum_set = 1'b0;
        mdl_total_wait = '0;
        mdl_total_turn = '0;
        mdl_total_resp = '0;
        mdl_finished = '0;
    endfunction

    // Apply one event to the model and return the result it should produce.
    function automatic out_item_t schedule_event(in_item_t ev);
        out_item_t r;
        int slot;
        logic [31:0] t;
        logic [31:0] elapsed;
        logic [31:0] turn;
        logic [31:0] wait_t;
        logic [31:0] resp;
        r = '0;
        t = ev.event_time;
        case (kind_t'(ev.kind))
            KIND_NEW:
            begin
                slot = -1;
                for (int i = JOB_SLOTS - 1; i >= 0; i--)
                    if (!mdl_valid[i]) slot = i;
                if (slot < 0)
                    r.status = ST_FULL;
                else
                begin
                    mdl_valid[slot] = 1'b1;
                    mdl_tag[slot] = ev.job_tag;
                    mdl_arrival[slot] = t;
                    mdl_start_set[slot] = 1'b0;
                    mdl_access_set[slot] = 1'b0;
                    mdl_start[slot] = '0;
                    mdl_access[slot] = '0;
                    mdl_length[slot] = ev.run_length;
                    mdl_remaining[slot] = ev.run_length;
                    mdl_priority[slot] = ev.job_priority;
                end
            end
            KIND_QUANTUM:
            begin
                if (!mdl_last_quantum_set)
                begin
                    mdl_last_quantum = t;
                    mdl_last_quantum_set = 1'b1;
                end
                slot = 0;
                if (!mdl_running)
                begin
                    slot = best_slot(1'b0);
                    if (slot < 0)
                        r.status = ST_IDLE;
                    else
                    begin
                        mdl_running = 1'b1;
                        mdl_run_slot = slot;
                    end
                end
                else
                begin
                    elapsed = (t >= mdl_last_quantum) ? t - mdl_last_quantum : '0;
                    mdl_remaining[mdl_run_slot] = (mdl_remaining[mdl_run_slot] > elapsed) ?
                        mdl_remaining[mdl_run_slot] - elapsed : '0;
                    mdl_access[mdl_run_slot] = t;
                    mdl_access_set[mdl_run_slot] = 1'b1;
                    if (mdl_policy == POL_PPRI || mdl_policy == POL_SRTF || mdl_policy == POL_RR)
                        mdl_run_slot = best_slot(1'b1);
                end
                if (slot >= 0)
                begin
                    if (!mdl_start_set[mdl_run_slot])
                    begin
                        mdl_start[mdl_run_slot] = t;
                        mdl_start_set[mdl_run_slot] = 1'b1;
                    end
                    mdl_last_quantum = t;
                    r.next_valid = 1'b1;
                    r.next_tag = mdl_tag[mdl_run_slot];
                end
            end
            KIND_FINISH:
            begin
                if (!mdl_running)
                    r.status = ST_IDLE;
                else
                begin
                    slot = mdl_run_slot;
                    turn = (t >= mdl_arrival[slot]) ? t - mdl_arrival[slot] : '0;
                    wait_t = (turn > mdl_length[slot]) ? turn - mdl_length[slot] : '0;
                    resp = (mdl_start[slot] >= mdl_arrival[slot]) ?
                        mdl_start[slot] - mdl_arrival[slot] : '0;
                    mdl_total_wait = add_capped(mdl_total_wait, wait_t);
                    mdl_total_turn = add_capped(mdl_total_turn, turn);
                    mdl_total_resp = add_capped(mdl_total_resp, resp);
                    if (mdl_finished != 16'hFFFF) mdl_finished++;
                    mdl_valid[slot] = 1'b0;
                    mdl_running = 1'b0;
                    mdl_run_slot = 0;
                end
            end
            default:
            begin
                if (mdl_finished == 0)
                    r.status = ST_NONE_FIN;
                else
                begin
                    r.avg_wait = 32'(mdl_total_wait / mdl_finished);
                    r.avg_turnaround = 32'(mdl_total_turn / mdl_finished);
                    r.avg_response = 32'(mdl_total_resp / mdl_finished);
                end
            end
        endcase
        r.finished_total = mdl_finished;
        return r;
    endfunction

    // Receiver: random stalls, plus a long hold-off when requested.
    initial
    begin
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                out_stall = 1'b1;
                repeat (long_hold) @(negedge clk);
                long_hold = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            out_stall = (gap != 0);
            if (gap != 0)
            begin
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
                out_stall = 1'b0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, out_data);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.status !== want.status)
                begin
                    $display("%0t status exp %0d got %0d", $time, want.status, out_data.status);
                    error_count++;
                end
                if (out_data.next_valid !== want.next_valid)
                begin
                    $display("%0t next_valid exp %0d got %0d", $time, want.next_valid,
                        out_data.next_valid);
                    error_count++;
                end
                if (out_data.next_tag !== want.next_tag)
                begin
                    $display("%0t next_tag exp %0d got %0d", $time, want.next_tag,
                        out_data.next_tag);
                    error_count++;
                end
                if (out_data.avg_wait !== want.avg_wait)
                begin
                    $display("%0t avg_wait exp %0d got %0d", $time, want.avg_wait,
                        out_data.avg_wait);
                    error_count++;
                end
                if (out_data.avg_turnaround !== want.avg_turnaround)
                begin
                    $display("%0t avg_turnaround exp %0d got %0d", $time,
                        want.avg_turnaround, out_data.avg_turnaround);
                    error_count++;
                end
                if (out_data.avg_response !== want.avg_response)
                begin
                    $display("%0t avg_response exp %0d got %0d", $time, want.avg_response,
                        out_data.avg_response);
                    error_count++;
                end
                if (out_data.finished_total !== want.finished_total)
                begin
                    $display("%0t finished_total exp %0d got %0d", $time,
                        want.finished_total, out_data.finished_total);
                    error_count++;
                end
            end
        end
    end

    // Send one request; the expectation is queued when it is accepted.
    task automatic send_request(logic [1:0] kind, logic [31:0] t, logic [7:0] tag,
        logic [31:0] len, logic [15:0] pri, bit no_gap = 0);
        int gap;
        in_item_t ev;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 4) == 0) gap = 0;
        repeat (gap) @(negedge clk);
        ev.kind = kind;
        ev.event_time = t;
        ev.job_tag = tag;
        ev.run_length = len;
        ev.job_priority = pri;
        in_data = ev;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_results.push_back(schedule_event(ev));
        @(negedge clk);
        in_valid = 1'b0;
        in_data = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    endtask

    // Wait for all results, then let the block settle before a register write.
    task automatic wait_idle();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_policy(logic [2:0] mode);
        wait_idle();
        cfg_data = mode;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        mdl_policy = mode;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random event with times moving forward mostly, backward sometimes.
    task automatic send_random(int new_weight, bit no_gap = 0);
        int pick;
        logic [1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < new_weight) kind = KIND_NEW;
        else if (pick < new_weight + (100 - new_weight) / 2) kind = KIND_QUANTUM;
        else if (pick < 95) kind = KIND_FINISH;
        else kind = KIND_QUERY;
        if ($urandom_range(0, 19) == 0) now_ticks = $urandom;
        else if ($urandom_range(0, 9) == 0) now_ticks = now_ticks - $urandom_range(0, 50);
        else now_ticks = now_ticks + $urandom_range(0, 40);
        send_request(kind, now_ticks, 8'($urandom),
            ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60),
            16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7)), no_gap);
    endtask

    // Directed: empty table, full table, extremes, time going backwards.
    task automatic test_directed();
        send_request(KIND_QUERY, 32'd5, 8'd0, 32'd0, 16'd0);
        send_request(KIND_QUANTUM, 32'd10, 8'd0, 32'd0, 16'd0);
        send_request(KIND_FINISH, 32'd11, 8'd0, 32'd0, 16'd0);
        for (int i = 0; i < JOB_SLOTS + 1; i++)
            send_request(KIND_NEW, 32'd20 + i, 8'(i * 15), (i == 3) ? 32'hFFFF_FFFF : 32'(i),
                (i == 2) ? 16'hFFFF : 16'(JOB_SLOTS - i));
        send_request(KIND_QUANTUM, 32'hFFFF_FFFF, 8'hFF, 32'd0, 16'd0);
        send_request(KIND_QUANTUM, 32'd3, 8'd0, 32'd0, 16'd0);
        send_request(KIND_FINISH, 32'd0, 8'd0, 32'd0, 16'd0);
        send_request(KIND_QUANTUM, 32'd40, 8'd0, 32'd0, 16'd0);
        send_request(KIND_FINISH, 32'hFFFF_FFFF, 8'd0, 32'd0, 16'd0);
        send_request(KIND_QUERY, 32'd0, 8'd0, 32'd0, 16'd0);
    endtask

    // Random phase under one policy.
    task automatic test_policy(logic [2:0] mode, int count);
        write_policy(mode);
        for (int i = 0; i < count; i++)
            send_random(35);
    endtask

    // Receiver holds off while the sender keeps offering requests.
    task automatic test_backpressure();
        long_hold = 300;
        for (int i = 0; i < 20; i++)
            send_random(40, 1);
    endtask

    // Random events under the two unused policy codes, 7 and then 6.
    task automatic test_code_extremes();
        write_policy(3'd7);
        for (int i = 0; i < 40; i++)
            send_random(30);
        write_policy(3'd6);
        for (int i = 0; i < 40; i++)
            send_random(30);
    endtask

    initial
    begin
        error_count = 0;
        long_hold = 0;
        now_ticks = 32'd100;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        model_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_policy(POL_SRTF, 60);
        test_backpressure();
        for (int p = 0; p < 6; p++)
            test_policy(3'(p), 230);
        test_code_extremes();
        test_policy(POL_RR, 40);
        wait_idle();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
